// ===== src/circular_deque_rear_push_two_end_pop_top_macros.svh =====
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_REAR_PUSH_TWO_END_POP_TOP_MACROS_SVH
`define CIRCULAR_DEQUE_REAR_PUSH_TWO_END_POP_TOP_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define CDQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A consequent that must hold in the cycle after the antecedent.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   `CDQ_ASSERT(label, clk, rst, (ante) |=> (cons), msg)

`endif

// ===== src/cdq_pkg.sv =====
// Package with the types, codes and defaults of the circular deque.
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 8;

   localparam logic [1:0] ACT_PUSH_REAR  = 2'd0;
   localparam logic [1:0] ACT_POP_REAR   = 2'd1;
   localparam logic [1:0] ACT_POP_FRONT  = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] push_value;
   } cdq_req_type;

   typedef struct packed {
      logic signed [31:0] popped_value;
      logic [1:0]         status;
   } cdq_rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic exec;
   } cdq_cmd_type;

endpackage

// ===== src/circular_deque_rear_push_two_end_pop_top.sv =====
// Top level of the input-restricted circular deque.
//
// A circular deque of DEPTH signed 32-bit words. Words enter only at the rear and leave
// from either the rear or the front. A transaction is accepted at a rising edge where
// start is high and busy is low; it carries an action (push at rear, pop from rear, pop
// from front; the fourth code does nothing and reports ok) and a word used by pushes.
// Every transaction yields exactly one result, shown on rsp_data for the single cycle
// in which rsp_valid is high, after the store-access state: the popped word (zero unless
// a pop succeeded) and a status of ok, full (push refused) or empty (pop refused).
// The receiver cannot stall results, so it must take each one in its strobe cycle.
// Busy is high only in the cycle after acceptance, while the entry store is accessed;
// a new transaction may be accepted in the cycle its predecessor's result is shown,
// but not during the store access that the registered read port of the store needs.
// No clearing pass follows reset: the store holds no defined contents until written,
// and only written entries are ever popped.
module circular_deque_rear_push_two_end_pop_top #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  cdq_pkg::cdq_req_type req_data,
   output logic                 rsp_valid,
   output cdq_pkg::cdq_rsp_type rsp_data
);

   cdq_pkg::cdq_cmd_type cmd;

   // The controller sequences each transaction: capture, store access, result strobe.
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // The datapath holds the indices, the empty flag, the entry store and the result.
   cdq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

// ===== src/cdq_ctrl.sv =====
// Controller state machine of the circular deque.
module cdq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_valid,
   output cdq_pkg::cdq_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign busy      = (state_ff == ST_EXEC);
   assign accept    = start && !busy;
   assign rsp_valid = (state_ff == ST_RESP);
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            state_in = accept ? ST_EXEC : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/cdq_dpath.sv =====
// Datapath of the circular deque: indices, empty flag, entry store and result.
module cdq_dpath #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cdq_pkg::cdq_cmd_type cmd,
   input  cdq_pkg::cdq_req_type req_data,
   output cdq_pkg::cdq_rsp_type rsp_data
);

   localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);

   logic signed [31:0] mem [DEPTH];

   cdq_pkg::cdq_req_type req_ff;
   logic [IdxW-1:0]      front_ff, front_in;
   logic [IdxW-1:0]      rear_ff, rear_in;
   logic                 empty_ff, empty_in;
   logic [1:0]           status_ff, status_in;
   logic                 pop_ok_ff, pop_ok_in;
   logic signed [31:0]   rd_data_ff;

   logic [IdxW-1:0] rear_next, rear_prev, front_next;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr, rd_addr;

   assign rear_next  = (rear_ff == LastIdx) ? '0 : rear_ff + 1'b1;
   assign rear_prev  = (rear_ff == '0) ? LastIdx : rear_ff - 1'b1;
   assign front_next = (front_ff == LastIdx) ? '0 : front_ff + 1'b1;

   always_comb begin
      front_in  = front_ff;
      rear_in   = rear_ff;
      empty_in  = empty_ff;
      status_in = status_ff;
      pop_ok_in = pop_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = rear_next;
      rd_addr   = front_ff;
      if (cmd.exec) begin
         status_in = cdq_pkg::STATUS_OK;
         pop_ok_in = 1'b0;
         unique case (req_ff.action)
            cdq_pkg::ACT_PUSH_REAR: begin
               if (empty_ff) begin
                  front_in = '0;
                  rear_in  = '0;
                  empty_in = 1'b0;
                  wr_en    = 1'b1;
                  wr_addr  = '0;
               end else if (rear_next == front_ff) begin
                  status_in = cdq_pkg::STATUS_FULL;
               end else begin
                  rear_in = rear_next;
                  wr_en   = 1'b1;
               end
            end
            cdq_pkg::ACT_POP_REAR, cdq_pkg::ACT_POP_FRONT: begin
               if (empty_ff) begin
                  status_in = cdq_pkg::STATUS_EMPTY;
               end else begin
                  pop_ok_in = 1'b1;
                  rd_addr   = (req_ff.action == cdq_pkg::ACT_POP_REAR) ? rear_ff : front_ff;
                  if (front_ff == rear_ff) begin
                     front_in = '0;
                     rear_in  = '0;
                     empty_in = 1'b1;
                  end else if (req_ff.action == cdq_pkg::ACT_POP_REAR) begin
                     rear_in = rear_prev;
                  end else begin
                     front_in = front_next;
                  end
               end
            end
            default: begin
               // The unused action code leaves everything as it is.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         rear_ff  <= '0;
         empty_ff <= 1'b1;
      end else begin
         front_ff <= front_in;
         rear_ff  <= rear_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      status_ff <= status_in;
      pop_ok_ff <= pop_ok_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= req_ff.push_value;
      if (cmd.exec) rd_data_ff <= mem[rd_addr];
   end

   assign rsp_data.popped_value = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_data.status       = status_ff;

endmodule

// ===== src/cdq_checker.sv =====
// Port-level checker of the circular deque and its bind to the top level.
`include "circular_deque_rear_push_two_end_pop_top_macros.svh"

module cdq_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input cdq_pkg::cdq_req_type req_data,
   input logic                 rsp_valid,
   input cdq_pkg::cdq_rsp_type rsp_data
);

   logic accept;
   logic refused;

   assign accept  = start && !busy;
   assign refused = (rsp_data.status != cdq_pkg::STATUS_OK);

   `CDQ_ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid, "no store cycle after accept")
   `CDQ_ASSERT_NEXT(a_busy_result, clock, reset, busy, rsp_valid && !busy, "result not shown after store cycle")
   `CDQ_ASSERT(a_result_once, clock, reset, rsp_valid |=> !rsp_valid || $past(accept), "result strobe repeated")
   `CDQ_ASSERT(a_status_code, clock, reset, rsp_valid |-> rsp_data.status != 2'd3, "unknown status code")
   `CDQ_ASSERT(a_refused_zero, clock, reset, rsp_valid && refused |-> rsp_data.popped_value == '0, "refused request returned a word")

   logic unused_req;
   assign unused_req = ^req_data;

endmodule

bind circular_deque_rear_push_two_end_pop_top cdq_checker u_cdq_checker (.*);
